// File: rtl/core/slot_pool_allocator_assert.svh
// Assertion macros used by the slot pool allocator datapath.
`ifndef SLOT_POOL_ALLOCATOR_ASSERT_SVH
`define SLOT_POOL_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define SPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SPA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPA_ASSERT_IMP(label, ante, cons, msg)
`define SPA_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/core/spa_pkg.sv
// Constants, codes and control types of the slot pool allocator.
package spa_pkg;

  localparam int SLOTS      = 32;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int COUNT_W    = $clog2(SLOTS + 1);
  localparam int INDEX_W    = 6;
  localparam int STATUS_W   = 3;
  localparam int OUT_SLOT_W = 5;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NONE_IN_USE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_USE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE       = 3'd4;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // datapath -> controller
  typedef struct packed {
    logic op;
    logic out_free;
    logic pool_empty;
    logic out_of_range;
    logic none_in_use;
    logic not_in_use;
  } sts_t;

  // controller -> datapath
  typedef struct packed {
    logic                ready;
    logic                issue_alloc;
    logic                issue_rel;
    logic                fin_alloc;
    logic                fin_rel;
    logic                err;
    logic [STATUS_W-1:0] err_code;
  } cmd_t;

endpackage

// File: rtl/core/spa_if.sv
// Request and response channel interfaces of the slot pool allocator.
interface spa_req_if import spa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [INDEX_W-1:0] index;

  modport source (output valid, output op, output index, input ready);
  modport sink (input valid, input op, input index, output ready);
endinterface

interface spa_rsp_if import spa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [OUT_SLOT_W-1:0] slot;
  logic                  head_valid;
  logic [OUT_SLOT_W-1:0] head_slot;

  modport source (output valid, output status, output slot, output head_valid,
                  output head_slot, input ready);
  modport sink (input valid, input status, input slot, input head_valid,
                input head_slot, output ready);
endinterface

// File: rtl/core/spa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/spa_ctrl.sv
// Controller state machine of the slot pool allocator.
module spa_ctrl import spa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_ALLOC   = 2'd1;
  localparam logic [1:0] S_RELEASE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // decode request, issue memory reads or reject at once
  always_comb begin
    cmd        = '0;
    cmd.err_code = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.ready = sts.out_free;
        if (sts.out_free && valid) begin
          if (sts.op == OP_ALLOC) begin
            if (sts.pool_empty) begin
              cmd.err      = 1'b1;
              cmd.err_code = ST_EMPTY;
            end else begin
              cmd.issue_alloc = 1'b1;
              state_next      = S_ALLOC;
            end
          end else begin
            priority if (sts.out_of_range) begin
              cmd.err      = 1'b1;
              cmd.err_code = ST_RANGE;
            end else if (sts.none_in_use) begin
              cmd.err      = 1'b1;
              cmd.err_code = ST_NONE_IN_USE;
            end else if (sts.not_in_use) begin
              cmd.err      = 1'b1;
              cmd.err_code = ST_NOT_IN_USE;
            end else begin
              cmd.issue_rel = 1'b1;
              state_next    = S_RELEASE;
            end
          end
        end
      end
      S_ALLOC: begin
        cmd.fin_alloc = 1'b1;
        state_next    = S_IDLE;
      end
      S_RELEASE: begin
        cmd.fin_rel = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/spa_dp.sv
// Datapath of the slot pool allocator: free stack, in-use links, flags, result register.
`include "slot_pool_allocator_assert.svh"
module spa_dp import spa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  op,
  input  logic [INDEX_W-1:0]    index,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   status,
  output logic [OUT_SLOT_W-1:0] slot,
  output logic                  head_valid,
  output logic [OUT_SLOT_W-1:0] head_slot
);

  // control state
  logic [COUNT_W-1:0] fc;
  logic [COUNT_W-1:0] low;
  logic [SLOT_W-1:0]  head;
  logic [SLOT_W-1:0]  tail;
  logic [SLOTS-1:0]   in_use;

  // held request data
  logic [SLOT_W-1:0]  pos_q;
  logic               fresh_q;
  logic [SLOT_W-1:0]  idx_q;

  // memory read data
  logic [SLOT_W-1:0]  stack_rdata;
  logic [SLOT_W-1:0]  prev_rdata;
  logic [SLOT_W-1:0]  next_rdata;

  logic [COUNT_W-1:0] top_pos;
  logic               list_empty;
  logic               single;
  logic [SLOT_W-1:0]  s;
  logic               is_head;
  logic               is_tail;
  logic               middle;
  logic               emit;

  logic               prev_we;
  logic [SLOT_W-1:0]  prev_waddr;
  logic [SLOT_W-1:0]  prev_wdata;
  logic               next_we;
  logic [SLOT_W-1:0]  next_waddr;
  logic [SLOT_W-1:0]  next_wdata;

  logic [STATUS_W-1:0]   status_next;
  logic [SLOT_W-1:0]     slot_next;
  logic                  hv_next;
  logic [SLOT_W-1:0]     hs_next;

  // request checks
  assign top_pos    = fc - COUNT_W'(1);
  assign list_empty = (fc == COUNT_W'(SLOTS));
  assign single     = (fc == COUNT_W'(SLOTS - 1));

  assign sts.op           = op;
  assign sts.out_free     = !out_valid || out_ready;
  assign sts.pool_empty   = (fc == '0);
  assign sts.out_of_range = ((INDEX_W + 1)'(index) >= (INDEX_W + 1)'(SLOTS));
  assign sts.none_in_use  = list_empty;
  assign sts.not_in_use   = !in_use[index[SLOT_W-1:0]];

  // slot popped: never-written entries of the stack are taken as SLOTS-1 minus their position
  assign s = fresh_q ? (SLOT_W'(SLOTS - 1) - pos_q) : stack_rdata;

  assign is_head = (idx_q == head);
  assign is_tail = (idx_q == tail);
  assign middle  = !single && !is_head && !is_tail;

  // link memory writes
  assign prev_we    = cmd.fin_alloc || (cmd.fin_rel && middle);
  assign prev_waddr = cmd.fin_alloc ? s : next_rdata;
  assign prev_wdata = cmd.fin_alloc ? tail : prev_rdata;
  assign next_we    = (cmd.fin_alloc && !list_empty) || (cmd.fin_rel && middle);
  assign next_waddr = cmd.fin_alloc ? tail : prev_rdata;
  assign next_wdata = cmd.fin_alloc ? s : next_rdata;

  spa_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_stack (
    .clk   (clk),
    .we    (cmd.fin_rel),
    .waddr (fc[SLOT_W-1:0]),
    .wdata (idx_q),
    .raddr (top_pos[SLOT_W-1:0]),
    .rdata (stack_rdata)
  );

  spa_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (index[SLOT_W-1:0]),
    .rdata (prev_rdata)
  );

  spa_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_next (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (index[SLOT_W-1:0]),
    .rdata (next_rdata)
  );

  // result of the step
  assign emit = cmd.err || cmd.fin_alloc || cmd.fin_rel;

  always_comb begin
    status_next = cmd.err_code;
    slot_next   = '0;
    hv_next     = !list_empty;
    hs_next     = list_empty ? '0 : head;
    if (cmd.fin_alloc) begin
      status_next = ST_OK;
      slot_next   = s;
      hv_next     = 1'b1;
      hs_next     = list_empty ? s : head;
    end else if (cmd.fin_rel) begin
      status_next = ST_OK;
      slot_next   = idx_q;
      hv_next     = !single;
      hs_next     = single ? '0 : (is_head ? next_rdata : head);
    end
  end

  // pool and list state
  always_ff @(posedge clk) begin
    if (rst) begin
      fc        <= COUNT_W'(SLOTS);
      low       <= COUNT_W'(SLOTS);
      head      <= '0;
      tail      <= '0;
      in_use    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.fin_alloc) begin
        fc        <= top_pos;
        in_use[s] <= 1'b1;
        tail      <= s;
        if (list_empty) begin
          head <= s;
        end
        if (fresh_q) begin
          low <= top_pos;
        end
      end
      if (cmd.fin_rel) begin
        fc            <= fc + COUNT_W'(1);
        in_use[idx_q] <= 1'b0;
        priority if (single) begin
          head <= '0;
          tail <= '0;
        end else if (is_head) begin
          head <= next_rdata;
        end else if (is_tail) begin
          tail <= prev_rdata;
        end
      end
    end
  end

  // held request and result payload
  always_ff @(posedge clk) begin
    if (cmd.issue_alloc) begin
      pos_q   <= top_pos[SLOT_W-1:0];
      fresh_q <= (top_pos < low);
    end
    if (cmd.issue_rel) begin
      idx_q <= index[SLOT_W-1:0];
    end
    if (emit) begin
      status     <= status_next;
      slot       <= OUT_SLOT_W'(slot_next);
      head_valid <= hv_next;
      head_slot  <= OUT_SLOT_W'(hs_next);
    end
  end

  `SPA_ASSERT_IMP(a_fc_bound, 1'b1, fc <= COUNT_W'(SLOTS), "free count above pool size")
  `SPA_ASSERT_IMP(a_low_bound, 1'b1, low <= fc, "fresh mark above free count")
  `SPA_ASSERT_IMP(a_flags_count, 1'b1, $countones(in_use) + int'(fc) == SLOTS, "in-use count off")
  `SPA_ASSERT_IMP(a_no_overwrite, cmd.fin_alloc || cmd.fin_rel, !out_valid, "result register overwritten")

endmodule

// File: rtl/core/slot_pool_allocator.sv
// Top level of the slot pool allocator.
// A pool of SLOTS numbered slots handed out from a LIFO free stack and tracked in an
// allocation-ordered, doubly linked in-use list. A request that is rejected (pool empty,
// out of range, nothing in use, slot not in use) is answered in the cycle after it is taken;
// an allocate or release that succeeds is finished in the S_ALLOC or S_RELEASE state that
// follows, as the free stack and the link tables sit in memories with registered read data
// that are read in the request cycle and updated in the next. One request is in work at a
// time; a new one is taken as soon as the controller is idle and the result register is
// empty or being emptied in that cycle. No clearing pass is needed after reset.
module slot_pool_allocator import spa_pkg::*; (
  input logic     clk,
  input logic     rst,
  spa_req_if.sink   req,
  spa_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  assign req.ready = cmd.ready;

  spa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (req.valid),
    .sts   (sts),
    .cmd   (cmd)
  );

  spa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (req.op),
    .index      (req.index),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .status     (rsp.status),
    .slot       (rsp.slot),
    .head_valid (rsp.head_valid),
    .head_slot  (rsp.head_slot)
  );

endmodule

// File: dv/slot_pool_checker.sv
// Reply checker for the slot pool allocator: predicts each reply and compares it.
`timescale 1ns / 100ps

module slot_pool_checker import spa_pkg::*; (
  input  logic clk,
  input  logic rst,
  spa_req_if   req,
  spa_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  head_valid;
    logic [OUT_SLOT_W-1:0] head_slot;
  } slot_reply_t;

  // Predicted pool: busy flags, LIFO of free slots, in-use list in allocation order
  logic              slot_busy  [SLOTS];
  logic [SLOT_W-1:0] free_lifo  [SLOTS];
  logic [SLOT_W-1:0] link_next  [SLOTS];
  logic [SLOT_W-1:0] link_prev  [SLOTS];
  int unsigned       free_left;
  logic [SLOT_W-1:0] list_first;
  logic [SLOT_W-1:0] list_last;

  slot_reply_t replies_due[$];

  initial fail_count = 0;

  function automatic void pool_clear();
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      free_lifo[i] = SLOT_W'(SLOTS - 1 - i);
      link_next[i] = '0;
      link_prev[i] = '0;
    end
    free_left  = SLOTS;
    list_first = '0;
    list_last  = '0;
  endfunction

  // Apply one request to the predicted pool and return the reply it gives
  function automatic slot_reply_t pool_step(input logic op, input logic [INDEX_W-1:0] idx);
    slot_reply_t       r;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] p;
    logic [SLOT_W-1:0] n;
    int unsigned       used;
    r    = '0;
    used = SLOTS - free_left;
    s    = idx[SLOT_W-1:0];
    if (op == OP_ALLOC) begin
      if (free_left == 0) begin
        r.status = ST_EMPTY;
      end else begin
        free_left--;
        s = free_lifo[free_left];
        slot_busy[s] = 1'b1;
        link_next[s] = '0;
        link_prev[s] = list_last;
        if (used == 0) begin
          list_first = s;
        end else begin
          link_next[list_last] = s;
        end
        list_last = s;
        r.status  = ST_OK;
        r.slot    = s;
      end
    end else if (idx >= SLOTS) begin
      r.status = ST_RANGE;
    end else if (used == 0) begin
      r.status = ST_NONE_IN_USE;
    end else if (!slot_busy[s]) begin
      r.status = ST_NOT_IN_USE;
    end else begin
      p = link_prev[s];
      n = link_next[s];
      // unlink: last entry, head, tail or middle of the list
      if (used == 1) begin
        list_first = '0;
        list_last  = '0;
      end else if (s == list_first) begin
        list_first   = n;
        link_prev[n] = '0;
      end else if (s == list_last) begin
        list_last    = p;
        link_next[p] = '0;
      end else begin
        link_next[p] = n;
        link_prev[n] = p;
      end
      slot_busy[s]         = 1'b0;
      free_lifo[free_left] = s;
      free_left++;
      r.status = ST_OK;
      r.slot   = s;
    end
    r.head_valid = (free_left < SLOTS);
    r.head_slot  = r.head_valid ? list_first : '0;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Replies are checked before the same edge's request is predicted
  always @(posedge clk) begin
    slot_reply_t want;
    if (rst) begin
      pool_clear();
      replies_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply, expected none, actual status %0d slot %0d",
                   $time, rsp.status, rsp.slot);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("slot", want.slot, rsp.slot);
          check_field("head_valid", want.head_valid, rsp.head_valid);
          check_field("head_slot", want.head_slot, rsp.head_slot);
        end
      end
      if (req.valid && req.ready) begin
        replies_due.push_back(pool_step(req.op, req.index));
      end
    end
    pending <= replies_due.size();
  end

endmodule

// File: dv/slot_pool_allocator_tb.sv
// Testbench top for the slot pool allocator: clock, reset, request and reply traffic.
`timescale 1ns / 100ps

module slot_pool_allocator_tb import spa_pkg::*; ();

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   replies_taken;
  int   stall_max;

  spa_req_if req_ch ();
  spa_rsp_if rsp_ch ();

  slot_pool_allocator u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  slot_pool_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Offer one request and wait until it is taken; valid is only lowered for a gap
  task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx, input int gap);
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding reply
  task automatic drain_replies();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Release index: mostly real slot numbers, sometimes out of range
  function automatic logic [INDEX_W-1:0] pick_index();
    if ($urandom_range(0, 99) < 12) begin
      return INDEX_W'($urandom_range(SLOTS, 63));
    end
    return INDEX_W'($urandom_range(0, SLOTS - 1));
  endfunction

  // Reply side: random stalls, calm stretches, and two long hold-offs
  initial begin
    rsp_ch.ready  = 1'b0;
    replies_taken = 0;
    stall_max     = 17;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (replies_taken == 250 || replies_taken == 650) begin
        rsp_ch.ready <= 1'b0;
        repeat (90) @(posedge clk);
      end else begin
        int stall;
        stall = $urandom_range(0, stall_max);
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      replies_taken++;
      if (replies_taken % 40 == 0) begin
        stall_max = ($urandom_range(0, 1) == 1) ? 17 : 0;
      end
    end
  end

  // Request side: directed opening, then rounds of fill, drain and mixed traffic
  initial begin
    int sent;
    int round;
    int round_len;
    int alloc_pct;
    int gap_max;
    logic op;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op    = OP_ALLOC;
    req_ch.index = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // rejects on an empty list, then a short list worked from head, middle and tail
    send_request(OP_RELEASE, 6'd5, 0);
    send_request(OP_RELEASE, 6'd32, 3);
    send_request(OP_RELEASE, 6'd63, 0);
    send_request(OP_ALLOC, 6'd0, 0);
    send_request(OP_ALLOC, 6'd0, 2);
    send_request(OP_ALLOC, 6'd0, 0);
    send_request(OP_ALLOC, 6'd0, 0);
    send_request(OP_RELEASE, 6'd7, 0);
    send_request(OP_RELEASE, 6'd2, 1);
    send_request(OP_RELEASE, 6'd0, 0);
    send_request(OP_RELEASE, 6'd3, 0);
    send_request(OP_ALLOC, 6'd0, 0);
    send_request(OP_ALLOC, 6'd0, 5);
    send_request(OP_RELEASE, 6'd1, 0);
    send_request(OP_RELEASE, 6'd3, 0);
    send_request(OP_RELEASE, 6'd0, 0);
    send_request(OP_RELEASE, 6'd0, 0);
    send_request(OP_ALLOC, 6'd63, 0);
    send_request(OP_ALLOC, 6'd42, 0);
    send_request(OP_RELEASE, 6'd31, 0);
    send_request(OP_RELEASE, 6'd21, 0);
    send_request(OP_RELEASE, 6'd42, 0);
    drain_replies();

    sent  = 0;
    round = 0;
    while (sent < 950) begin
      if (round == 0) begin
        // fill the whole pool and run past empty
        round_len = 40;
        alloc_pct = 100;
      end else begin
        round_len = $urandom_range(30, 70);
        case ($urandom_range(0, 2))
          0: alloc_pct = 85;
          1: alloc_pct = 15;
          default: alloc_pct = 50;
        endcase
      end
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
      for (int i = 0; i < round_len; i++) begin
        op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_RELEASE;
        send_request(op, (op == OP_ALLOC) ? INDEX_W'($urandom) : pick_index(),
                     $urandom_range(0, gap_max));
        sent++;
      end
      if (round == 7) begin
        drain_replies();
      end
      round++;
    end

    drain_replies();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("slot_pool_allocator test passed");
    end else begin
      $display("slot_pool_allocator test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("slot_pool_allocator test failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/spa_pkg.sv
rtl/core/spa_if.sv
rtl/core/spa_ram.sv
rtl/core/spa_ctrl.sv
rtl/core/spa_dp.sv
rtl/core/slot_pool_allocator.sv
dv/slot_pool_checker.sv
dv/slot_pool_allocator_tb.sv
